>>> sv/bdw_pkg.sv
// Shared constants and codes of the binary dilation window block.
// Depends on nothing; every other file of the block but bdw_ram imports it.

package bdw_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int DIM_W       = 12;
    localparam int RAD_W       = 5;
    localparam int MODE_W      = 2;
    localparam int QUEUE_DEPTH = 4;

    // A pixel counts as set only at full scale; results are full scale or zero.
    localparam logic [PIX_W-1:0] PIX_SET   = 8'd255;
    localparam logic [PIX_W-1:0] PIX_CLEAR = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_ROW_RADIUS   = 3'd2,
        REG_COL_RADIUS   = 3'd3,
        REG_WINDOW_MODE  = 3'd4
    } reg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_HORIZONTAL = 2'd0,
        MODE_VERTICAL   = 2'd1,
        MODE_RECTANGLE  = 2'd2
    } window_mode_t;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 12'd480;
    localparam logic [RAD_W-1:0]  RST_ROW_RADIUS   = 5'd2;
    localparam logic [RAD_W-1:0]  RST_COL_RADIUS   = 5'd5;
    localparam logic [MODE_W-1:0] RST_WINDOW_MODE  = 2'd2;

endpackage

>>> sv/bdw_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.

module bdw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/bdw_front.sv
// Front end: register file, raster counters and classification of each item.
// Depends on bdw_pkg; the item and geometry struct types come from the top level.

module bdw_front #(
    parameter int  MAX_WIDTH      = 2048,
    parameter int  MAX_HEIGHT     = 2048,
    parameter int  MAX_ROW_RADIUS = 16,
    parameter int  MAX_COL_RADIUS = 16,
    parameter type entry_t        = logic,
    parameter type geom_t         = logic
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bdw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bdw_pkg::PIX_W-1:0]       in_pixel,
    input  logic                            in_flush,
    output logic                            push_valid,
    input  logic                            push_ready,
    output entry_t                          push_entry,
    output geom_t                           geom
);

    import bdw_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + MAX_ROW_RADIUS + MAX_COL_RADIUS + 2);
    localparam int RR_W  = $clog2(MAX_ROW_RADIUS + 1);
    localparam int CR_W  = $clog2(MAX_COL_RADIUS + 1);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [RAD_W-1:0]  row_rad_reg;
    logic [RAD_W-1:0]  col_rad_reg;
    logic [MODE_W-1:0] mode_reg;

    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [CR_W-1:0]  lead_reg;
    logic [COL_W-1:0] ctr_col_reg;
    logic [ROW_W-1:0] ctr_row_reg;

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [RR_W-1:0]  r_clamp;
    logic [CR_W-1:0]  c_clamp;
    logic [RR_W-1:0]  r_eff;
    logic [CR_W-1:0]  c_eff;
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] last_row;
    logic             cfg_restart;
    logic             accept;

    // Effective geometry: zero sizes act as one, oversize values saturate.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WID_W'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = WID_W'(width_reg);

        if (height_reg == '0)
            h_eff = HGT_W'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = HGT_W'(MAX_HEIGHT);
        else
            h_eff = HGT_W'(height_reg);

        if (32'(row_rad_reg) > 32'(MAX_ROW_RADIUS))
            r_clamp = RR_W'(MAX_ROW_RADIUS);
        else
            r_clamp = RR_W'(row_rad_reg);

        if (32'(col_rad_reg) > 32'(MAX_COL_RADIUS))
            c_clamp = CR_W'(MAX_COL_RADIUS);
        else
            c_clamp = CR_W'(col_rad_reg);

        // The unused mode code behaves as a rectangle.
        case (window_mode_t'(mode_reg))
            MODE_HORIZONTAL:
            begin
                r_eff = '0;
                c_eff = c_clamp;
            end
            MODE_VERTICAL:
            begin
                r_eff = r_clamp;
                c_eff = '0;
            end
            default:
            begin
                r_eff = r_clamp;
                c_eff = c_clamp;
            end
        endcase

        w_last   = COL_W'(w_eff - WID_W'(1));
        last_row = ROW_W'(h_eff) - ROW_W'(1) + ROW_W'(r_eff);
    end

    assign geom.w        = w_eff;
    assign geom.h        = h_eff;
    assign geom.last_row = last_row;
    assign geom.r        = r_eff;
    assign geom.c        = c_eff;

    // Only writes to a listed register restart the frame.
    always_comb
    begin
        case (reg_index_t'(cfg_index))
            REG_FRAME_WIDTH,
            REG_FRAME_HEIGHT,
            REG_ROW_RADIUS,
            REG_COL_RADIUS,
            REG_WINDOW_MODE: cfg_restart = cfg_valid;
            default:         cfg_restart = 1'b0;
        endcase
    end

    assign cfg_ready  = 1'b1;
    assign push_valid = in_valid;
    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;

    // The window center trails the input by c items; hv marks items that have one.
    always_comb
    begin
        push_entry.set  = (in_row_reg < ROW_W'(h_eff)) && !in_flush && (in_pixel == PIX_SET);
        push_entry.hv   = (lead_reg == c_eff);
        push_entry.emit = push_entry.hv && (ctr_row_reg >= ROW_W'(r_eff));
        push_entry.last = push_entry.hv && (ctr_row_reg == last_row) && (ctr_col_reg == w_last);
        push_entry.col  = ctr_col_reg;
        push_entry.row  = ctr_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_FRAME_WIDTH;
            height_reg  <= RST_FRAME_HEIGHT;
            row_rad_reg <= RST_ROW_RADIUS;
            col_rad_reg <= RST_COL_RADIUS;
            mode_reg    <= RST_WINDOW_MODE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            lead_reg    <= '0;
            ctr_col_reg <= '0;
            ctr_row_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (reg_index_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_reg   <= cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT: height_reg  <= cfg_data[DIM_W-1:0];
                    REG_ROW_RADIUS:   row_rad_reg <= cfg_data[RAD_W-1:0];
                    REG_COL_RADIUS:   col_rad_reg <= cfg_data[RAD_W-1:0];
                    REG_WINDOW_MODE:  mode_reg    <= cfg_data[MODE_W-1:0];
                    default:          ;
                endcase
            end

            if (cfg_restart || (accept && push_entry.last))
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                lead_reg    <= '0;
                ctr_col_reg <= '0;
                ctr_row_reg <= '0;
            end
            else if (accept)
            begin
                if (in_col_reg == w_last)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end

                if (push_entry.hv)
                begin
                    if (ctr_col_reg == w_last)
                    begin
                        ctr_col_reg <= '0;
                        ctr_row_reg <= ctr_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        ctr_col_reg <= ctr_col_reg + COL_W'(1);
                    end
                end
                else
                begin
                    lead_reg <= lead_reg + CR_W'(1);
                end
            end
        end
    end

endmodule

>>> sv/bdw_queue.sv
// Short register queue that decouples the front end from the window back end.
// Depends on bdw_pkg; the item type comes from the instantiating module.

module bdw_queue #(
    parameter int  DEPTH   = 4,
    parameter type entry_t = logic
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_entry
);

    import bdw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> sv/bdw_back.sv
// Back end: horizontal window OR, per-column row history in RAM, vertical OR, output register.
// Depends on bdw_pkg and bdw_ram; the item and geometry struct types come from the top level.

module bdw_back #(
    parameter int  MAX_WIDTH      = 2048,
    parameter int  MAX_HEIGHT     = 2048,
    parameter int  MAX_ROW_RADIUS = 16,
    parameter int  MAX_COL_RADIUS = 16,
    parameter type entry_t        = logic,
    parameter type geom_t         = logic
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  geom_t                     geom,
    input  logic                      entry_valid,
    output logic                      entry_ready,
    input  entry_t                    entry,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [bdw_pkg::PIX_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);

    import bdw_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SR_W   = 2 * MAX_COL_RADIUS + 1;
    localparam int HIST_W = 2 * MAX_ROW_RADIUS;
    localparam int XW     = $clog2(MAX_WIDTH + 2 * MAX_COL_RADIUS + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + MAX_ROW_RADIUS + MAX_COL_RADIUS + 2);
    localparam int MW     = $clog2(HIST_W + 1);
    localparam int KW     = (ROW_W > MW) ? ROW_W : MW;

    // Window stage state.
    logic [SR_W-1:0]   sr_reg;
    logic [SR_W-1:0]   sr_next;
    logic              h_next;
    logic [HIST_W-1:0] mask_next;
    logic [XW-1:0]     span;
    logic [XW-1:0]     ctr_plus_c;
    logic [XW-1:0]     w_minus1;
    logic [KW-1:0]     r_span;
    logic [KW-1:0]     ctr_row_k;
    logic              fwd_next;

    // Vertical stage state.
    logic              b2_valid_reg;
    logic              b2_hv_reg;
    logic              b2_emit_reg;
    logic              b2_last_reg;
    logic [COL_W-1:0]  b2_col_reg;
    logic              b2_h_reg;
    logic [HIST_W-1:0] b2_mask_reg;
    logic              fwd_hit_reg;
    logic [HIST_W-1:0] fwd_data_reg;
    logic [HIST_W-1:0] ram_rd_data;
    logic [HIST_W-1:0] hist;
    logic [HIST_W-1:0] hist_next;
    logic              vert_hit;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              b1_go;
    logic              b2_go;

    assign out_free    = !out_valid_reg || m_axis_tready;
    assign b2_go       = b2_valid_reg && (!b2_emit_reg || out_free);
    assign entry_ready = !b2_valid_reg || b2_go;
    assign b1_go       = entry_valid && entry_ready;

    // Horizontal window: bit t of the shift line sits c-t columns right of the
    // center. A bit counts only inside the window and inside the center's row.
    always_comb
    begin
        sr_next    = {sr_reg[SR_W-2:0], entry.set};
        span       = XW'({geom.c, 1'b0});
        ctr_plus_c = XW'(entry.col) + XW'(geom.c);
        w_minus1   = XW'(geom.w) - XW'(1);
        h_next     = 1'b0;
        for (int t = 0; t < SR_W; t++)
        begin
            if (sr_next[t] && (XW'(t) <= span) && (XW'(t) <= ctr_plus_c)
                && (XW'(t) + w_minus1 >= ctr_plus_c))
            begin
                h_next = 1'b1;
            end
        end
    end

    // Vertical mask: history bit m-1 holds the row m above the item's row; it
    // counts when within reach and not above the top of the frame.
    always_comb
    begin
        r_span    = KW'({geom.r, 1'b0});
        ctr_row_k = KW'(entry.row);
        for (int m = 1; m <= HIST_W; m++)
        begin
            mask_next[m-1] = (KW'(m) <= r_span) && (KW'(m) <= ctr_row_k);
        end
    end

    // A read of the column being written in the same cycle takes the new word.
    assign fwd_next  = b2_go && b2_hv_reg && (b2_col_reg == entry.col);

    assign hist      = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
    assign vert_hit  = b2_h_reg || (|(hist & b2_mask_reg));
    assign hist_next = {hist[HIST_W-2:0], b2_h_reg};

    bdw_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_hist (
        .clk     (clk),
        .wr_en   (b2_go && b2_hv_reg),
        .wr_addr (b2_col_reg),
        .wr_data (hist_next),
        .rd_en   (b1_go && entry.hv),
        .rd_addr (entry.col),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg        <= '0;
            b2_valid_reg  <= 1'b0;
            b2_hv_reg     <= 1'b0;
            b2_emit_reg   <= 1'b0;
            b2_last_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_go)
            begin
                sr_reg       <= sr_next;
                b2_valid_reg <= 1'b1;
                b2_hv_reg    <= entry.hv;
                b2_emit_reg  <= entry.emit;
                b2_last_reg  <= entry.last;
                fwd_hit_reg  <= fwd_next;
            end
            else if (b2_go)
            begin
                b2_valid_reg <= 1'b0;
            end

            if (b2_go && b2_emit_reg)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_go)
        begin
            b2_col_reg   <= entry.col;
            b2_h_reg     <= h_next;
            b2_mask_reg  <= mask_next;
            fwd_data_reg <= hist_next;
        end
        if (b2_go && b2_emit_reg)
        begin
            out_pixel_reg <= vert_hit ? PIX_SET : PIX_CLEAR;
            out_last_reg  <= b2_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> sv/binary_dilation_window.sv
// Top level of the streaming binary dilation window.
// Depends on bdw_pkg, bdw_front, bdw_queue, bdw_back and bdw_ram.

// Streaming binary dilation of a grey image sent in raster order. An input
// pixel counts as set only when it equals 255; each result is 255 when any set
// pixel of the frame lies within the window around its position, else 0. The
// window is a rectangle of 2R+1 rows by 2C+1 columns, a single row (R forced to
// zero) or a single column (C forced to zero), clipped at the frame edges.
// Results come out in raster order and lag the inputs by R*W+C items: after the
// last pixel of a frame, send that many items with tuser high (flush) to push
// out the rest; the final result of the frame carries tlast, and the next item
// starts a new frame. Any write to a listed register restarts the frame and the
// new settings apply from the next item; write only while the block is idle.
// Software normally sets R = max(2, H/400) and C = max(5, W/150). Sizes of zero
// act as one and oversize sizes or radii saturate at the build limits.
// Throughput is one item per clock unless a stalled output holds the flow: the
// front end classifies each item against its raster counters and queues it,
// the back end ORs a 2*MAX_COL_RADIUS+1 bit shift line for the horizontal pass
// and does one read and one write of a per-column history word
// (2*MAX_ROW_RADIUS bits, MAX_WIDTH words) for the vertical pass, a fresh column
// every clock. An accepted item passes the queue, at whose head the window
// stage works on it and issues the memory read, then the vertical stage
// registers, then the output register. A stalled output does not stop input
// until the four-entry queue fills. The history memory needs no clearing pass
// after reset: rows above the top of the frame are masked off.

module binary_dilation_window #(
    parameter int MAX_WIDTH      = 2048,
    parameter int MAX_HEIGHT     = 2048,
    parameter int MAX_ROW_RADIUS = 16,
    parameter int MAX_COL_RADIUS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bdw_pkg::PIX_W-1:0]       s_axis_tdata,  // [7:0] pixel_in
    input  logic                            s_axis_tuser,  // [0] flush
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bdw_pkg::PIX_W-1:0]       m_axis_tdata,  // [7:0] pixel_out
    output logic                            m_axis_tlast,  // frame_last
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bdw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import bdw_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + MAX_ROW_RADIUS + MAX_COL_RADIUS + 2);
    localparam int RR_W  = $clog2(MAX_ROW_RADIUS + 1);
    localparam int CR_W  = $clog2(MAX_COL_RADIUS + 1);

    // Effective frame geometry after clamping and window mode.
    typedef struct packed {
        logic [WID_W-1:0] w;
        logic [HGT_W-1:0] h;
        logic [ROW_W-1:0] last_row;
        logic [RR_W-1:0]  r;
        logic [CR_W-1:0]  c;
    } geom_t;

    // One classified item: its set bit, whether it carries a window center
    // (hv), whether that center yields a result (emit), and the center position.
    typedef struct packed {
        logic             set;
        logic             hv;
        logic             emit;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } entry_t;

    geom_t  geom;
    entry_t push_entry;
    entry_t pop_entry;
    logic   push_valid;
    logic   push_ready;
    logic   pop_valid;
    logic   pop_ready;

    bdw_front #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .MAX_ROW_RADIUS (MAX_ROW_RADIUS),
        .MAX_COL_RADIUS (MAX_COL_RADIUS),
        .entry_t        (entry_t),
        .geom_t         (geom_t)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_pixel   (s_axis_tdata),
        .in_flush   (s_axis_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .geom       (geom)
    );

    bdw_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .entry_t (entry_t)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    bdw_back #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .MAX_ROW_RADIUS (MAX_ROW_RADIUS),
        .MAX_COL_RADIUS (MAX_COL_RADIUS),
        .entry_t        (entry_t),
        .geom_t         (geom_t)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .geom          (geom),
        .entry_valid   (pop_valid),
        .entry_ready   (pop_ready),
        .entry         (pop_entry),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> sv/bdw_checker.sv
// Port-level assertions for the binary dilation window, bound to the top level.
// Depends on bdw_pkg and binary_dilation_window.

module bdw_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [bdw_pkg::PIX_W-1:0] m_axis_tdata,
    input logic                      m_axis_tlast
);

    import bdw_pkg::*;

    // A result that is not taken stays on the bus unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed or dropped while stalled");

    // Results are binary pixels.
    a_out_binary: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata == PIX_SET || m_axis_tdata == PIX_CLEAR))
        else $error("output pixel is neither set nor clear");

    // The input side can only run out of room right after taking an item.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("input ready dropped without an accepted item");

    // Nothing is offered on the output in the first cycle after reset.
    a_reset_quiet: assert property (@(posedge clk)
        !$past(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind binary_dilation_window bdw_checker u_bdw_checker (.*);
